// File: sv/edta_pkg.sv
// Shared types, codes and constants for the echo time distance averager.
// Used by the register block, controller, datapath, top level and checker.
`timescale 1ns / 1ps
`default_nettype none

package edta_pkg;

  // Speed factor: 2248 / 65536 cm per microsecond; the Q8 scale leaves a net shift of 8
  localparam logic [11:0] SPEED_MUL = 12'd2248;

  // Restoring divide: one quotient bit per cycle over the 26-bit sum
  localparam int SUM_W      = 26;
  localparam int DIV_STEPS  = SUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // APB register map
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] REG_MIN_DIST     = 2'd1;
  localparam logic [1:0] REG_MAX_DIST     = 2'd2;
  localparam logic [1:0] REG_OFFSET       = 2'd3;

  // Sample status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_ECHO   = 3'd1;
  localparam logic [2:0] ST_BELOW_MIN = 3'd2;
  localparam logic [2:0] ST_ABOVE_MAX = 3'd3;
  localparam logic [2:0] ST_NOT_POS   = 3'd4;

  typedef struct packed {
    logic        echo_seen;
    logic [14:0] echo_us;
  } in_data_t;

  typedef struct packed {
    logic [17:0] sample_q8;
    logic [2:0]  sample_status;
    logic        average_ready;
    logic [17:0] average_q8;
    logic        all_failed;
  } out_data_t;

  typedef struct packed {
    logic [7:0]         sample_count;
    logic [9:0]         min_distance_cm;
    logic [9:0]         max_distance_cm;
    logic signed [15:0] offset_q8;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_DIV,
    S_LOAD
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic chk;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic meas_end;
    logic div_skip;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: sv/echo_time_distance_averager.sv
// Echo time distance averager: each accepted echo sample (seen flag, width in us)
// becomes a Q8 centimetre distance, (width/2)*2248 >> 8, checked against the
// min/max limits and corrected by the offset, and is returned with a status code.
// The last sample of a measurement also carries the truncated mean of its good
// samples, or all_failed. Each sample is captured, multiplied, checked and loaded
// into the output register; the last sample of a measurement, unless all of its
// samples failed, also runs the bit-serial restoring divider between check and
// load. One sample is in flight at a time; the next is accepted while the
// previous result waits in the output register. Depends on edta_pkg, edta_regs, edta_ctrl and edta_dp.
`timescale 1ns / 1ps
`default_nettype none

module echo_time_distance_averager (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire edta_pkg::in_data_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output edta_pkg::out_data_t                  out_data,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [edta_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic      [31:0]                     cfg_prdata,
  output logic                                 cfg_pready
);

  edta_pkg::cfg_t       cfg;
  edta_pkg::ctrl_cmd_t  cmd;
  edta_pkg::dp_status_t sts;

  edta_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  edta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  edta_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: sv/edta_regs.sv
// APB configuration registers of the echo time distance averager.
// Depends on edta_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module edta_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [edta_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                     cfg_pwdata,
  output logic      [31:0]                     cfg_prdata,
  output logic                                 cfg_pready,
  output edta_pkg::cfg_t                       cfg
);

  logic [7:0]  sample_count_r, sample_count_nxt;
  logic [9:0]  min_dist_r, min_dist_nxt;
  logic [9:0]  max_dist_r, max_dist_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  // Decode the write transaction
  always_comb begin
    sample_count_nxt = sample_count_r;
    min_dist_nxt     = min_dist_r;
    max_dist_nxt     = max_dist_r;
    offset_nxt       = offset_r;
    if (wr_en) begin
      unique case (reg_idx)
        edta_pkg::REG_SAMPLE_COUNT: sample_count_nxt = cfg_pwdata[7:0];
        edta_pkg::REG_MIN_DIST:     min_dist_nxt     = cfg_pwdata[9:0];
        edta_pkg::REG_MAX_DIST:     max_dist_nxt     = cfg_pwdata[9:0];
        edta_pkg::REG_OFFSET:       offset_nxt       = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= 8'd1;
      min_dist_r     <= 10'd20;
      max_dist_r     <= 10'd600;
      offset_r       <= 16'd0;
    end else begin
      sample_count_r <= sample_count_nxt;
      min_dist_r     <= min_dist_nxt;
      max_dist_r     <= max_dist_nxt;
      offset_r       <= offset_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      edta_pkg::REG_SAMPLE_COUNT: cfg_prdata = {24'd0, sample_count_r};
      edta_pkg::REG_MIN_DIST:     cfg_prdata = {22'd0, min_dist_r};
      edta_pkg::REG_MAX_DIST:     cfg_prdata = {22'd0, max_dist_r};
      edta_pkg::REG_OFFSET:       cfg_prdata = {16'd0, offset_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.sample_count    = sample_count_r;
  assign cfg.min_distance_cm = min_dist_r;
  assign cfg.max_distance_cm = max_dist_r;
  assign cfg.offset_q8       = $signed(offset_r);

endmodule

`default_nettype wire

// File: sv/edta_ctrl.sv
// Controller state machine: sequences capture, multiply, check, divide and output load.
// Depends on edta_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module edta_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire edta_pkg::dp_status_t sts,
  output edta_pkg::ctrl_cmd_t       cmd
);

  edta_pkg::ctrl_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edta_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      edta_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = edta_pkg::S_MUL;
        end
      end
      edta_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = edta_pkg::S_CHK;
      end
      edta_pkg::S_CHK: begin
        cmd.chk = 1'b1;
        if (sts.meas_end && !sts.div_skip) begin
          state_nxt = edta_pkg::S_DIV;
        end else begin
          state_nxt = edta_pkg::S_LOAD;
        end
      end
      edta_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = edta_pkg::S_LOAD;
        end
      end
      edta_pkg::S_LOAD: begin
        // Wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = edta_pkg::S_IDLE;
        end
      end
      default: state_nxt = edta_pkg::S_IDLE;
    endcase
  end

  // Hold the result until its transaction completes
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: sv/edta_dp.sv
// Datapath: width-to-distance multiply, limit and offset checks, accumulators,
// restoring divider and output register. Depends on edta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edta_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire edta_pkg::in_data_t   in_data,
  input  wire edta_pkg::cfg_t       cfg,
  input  wire edta_pkg::ctrl_cmd_t  cmd,
  output edta_pkg::dp_status_t      sts,
  output edta_pkg::out_data_t       out_data
);

  localparam int SW = edta_pkg::SUM_W;
  localparam int CW = edta_pkg::DIV_CNT_W;

  // Input capture and product
  logic                echo_seen_r, echo_seen_nxt;
  logic [13:0]         half_r, half_nxt;
  logic [SW-1:0]       prod_r, prod_nxt;

  // Measurement accumulators
  logic [7:0]          taken_r, taken_nxt;
  logic [7:0]          bad_r, bad_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;

  // Per-sample result
  logic [17:0]         sample_r, sample_nxt;
  logic [2:0]          status_r, status_nxt;
  logic                end_r, end_nxt;
  logic                failed_r, failed_nxt;

  // Divider
  logic [SW-1:0]       quo_r, quo_nxt;
  logic [7:0]          rem_r, rem_nxt;
  logic [8:0]          dvs_r, dvs_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  edta_pkg::out_data_t out_r, out_nxt;

  // Check signals
  logic [17:0]         raw_q8;
  logic [18:0]         adj;
  logic                adj_pos;
  logic [2:0]          chk_status;
  logic [17:0]         chk_sample;
  logic [7:0]          target;
  logic [7:0]          taken_inc;
  logic [7:0]          bad_inc;
  logic [SW-1:0]       sum_inc;
  logic                meas_end;
  logic [8:0]          taken9;
  logic [8:0]          good;
  logic [8:0]          rem_sh;
  logic                q_bit;

  // Capture the sample and form the product
  always_comb begin
    echo_seen_nxt = cmd.load_in ? in_data.echo_seen : echo_seen_r;
    half_nxt      = cmd.load_in ? in_data.echo_us[14:1] : half_r;
    prod_nxt      = cmd.mul ? (SW'(half_r) * SW'(edta_pkg::SPEED_MUL)) : prod_r;
  end

  // Classify the sample: no echo, below min, above max, distance not positive after the offset
  always_comb begin
    raw_q8  = prod_r[SW-1:8];
    adj     = {1'b0, raw_q8} - {{3{cfg.offset_q8[15]}}, cfg.offset_q8};
    adj_pos = !adj[18] && (adj != 19'd0);
    chk_sample = 18'd0;
    if (!echo_seen_r) begin
      chk_status = edta_pkg::ST_NO_ECHO;
    end else if (raw_q8 < {cfg.min_distance_cm, 8'd0}) begin
      chk_status = edta_pkg::ST_BELOW_MIN;
    end else if (raw_q8 > {cfg.max_distance_cm, 8'd0}) begin
      chk_status = edta_pkg::ST_ABOVE_MAX;
    end else if (cfg.offset_q8 != 16'sd0) begin
      if (adj_pos) begin
        chk_status = edta_pkg::ST_OK;
        chk_sample = adj[17:0];
      end else begin
        chk_status = edta_pkg::ST_NOT_POS;
      end
    end else begin
      chk_status = edta_pkg::ST_OK;
      chk_sample = raw_q8;
    end
  end

  // Advance the accumulators and detect the measurement end
  always_comb begin
    target    = (cfg.sample_count == 8'd0) ? 8'd1 : cfg.sample_count;
    taken_inc = taken_r + 8'd1;
    bad_inc   = (chk_status != edta_pkg::ST_OK) ? bad_r + 8'd1 : bad_r;
    sum_inc   = sum_r + SW'(chk_sample);
    meas_end  = (taken_inc >= target) || (taken_inc == 8'd0);
    taken9    = (taken_inc == 8'd0) ? 9'd256 : {1'b0, taken_inc};
    good      = (taken9 >= {1'b0, bad_inc}) ? taken9 - {1'b0, bad_inc} : 9'd0;
  end

  assign sts.meas_end = meas_end;
  assign sts.div_skip = (good == 9'd0);
  assign sts.div_last = (cnt_r == CW'(edta_pkg::DIV_STEPS - 1));

  // One restoring divide step
  always_comb begin
    rem_sh = {rem_r, quo_r[SW-1]};
    q_bit  = (rem_sh >= dvs_r);
  end

  always_comb begin
    taken_nxt  = taken_r;
    bad_nxt    = bad_r;
    sum_nxt    = sum_r;
    sample_nxt = sample_r;
    status_nxt = status_r;
    end_nxt    = end_r;
    failed_nxt = failed_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    cnt_nxt    = cnt_r;
    if (cmd.chk) begin
      sample_nxt = chk_sample;
      status_nxt = chk_status;
      end_nxt    = meas_end;
      failed_nxt = meas_end && (good == 9'd0);
      if (meas_end) begin
        // Start the divide and restart the measurement
        quo_nxt   = sum_inc;
        rem_nxt   = 8'd0;
        dvs_nxt   = good;
        cnt_nxt   = '0;
        taken_nxt = 8'd0;
        bad_nxt   = 8'd0;
        sum_nxt   = '0;
      end else begin
        taken_nxt = taken_inc;
        bad_nxt   = bad_inc;
        sum_nxt   = sum_inc;
      end
    end
    if (cmd.div_step) begin
      rem_nxt = q_bit ? 8'(rem_sh - dvs_r) : rem_sh[7:0];
      quo_nxt = {quo_r[SW-2:0], q_bit};
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // Load the output register
  always_comb begin
    out_nxt = out_r;
    if (cmd.out_load) begin
      out_nxt.sample_q8     = sample_r;
      out_nxt.sample_status = status_r;
      out_nxt.average_ready = end_r;
      out_nxt.average_q8    = (end_r && !failed_r) ? quo_r[17:0] : 18'd0;
      out_nxt.all_failed    = failed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 8'd0;
      bad_r   <= 8'd0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      taken_r <= taken_nxt;
      bad_r   <= bad_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    echo_seen_r <= echo_seen_nxt;
    half_r      <= half_nxt;
    prod_r      <= prod_nxt;
    sample_r    <= sample_nxt;
    status_r    <= status_nxt;
    end_r       <= end_nxt;
    failed_r    <= failed_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    out_r       <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: sv/edta_checker.sv
// Port-level checker for the echo time distance averager, with its bind.
// Depends on edta_pkg and the top-level port list.
`timescale 1ns / 1ps
`default_nettype none

module edta_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire edta_pkg::out_data_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // One sample in flight: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // Drop the distance of a failed sample
  a_bad_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.sample_status != edta_pkg::ST_OK) |-> out_data.sample_q8 == 18'd0)
    else $error("failed sample carries a distance");

  // Average fields only on the last sample of a measurement
  a_avg_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.average_ready |->
      out_data.average_q8 == 18'd0 && !out_data.all_failed)
    else $error("average fields set outside measurement end");

  a_failed_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.all_failed |-> out_data.average_q8 == 18'd0)
    else $error("all-failed measurement carries an average");

endmodule

bind echo_time_distance_averager edta_checker u_edta_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
